// ----- design/mirror_bilinear_pixel_sampler_top_defines.svh -----
// assertion macros for the mirror bilinear pixel sampler
// no dependencies; included by the top level only
`ifndef MIRROR_BILINEAR_PIXEL_SAMPLER_TOP_DEFINES_SVH
`define MIRROR_BILINEAR_PIXEL_SAMPLER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, off during reset
`define MBPS_ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);
// next-cycle implication, also checked out of reset
`define MBPS_ASSERT_NEXT(lbl, clk, trig, cons, msg) \
  lbl: assert property (@(posedge clk) (trig) |=> (cons)) else $error(msg);
`else
`define MBPS_ASSERT_IMPLY(lbl, clk, rst, trig, cons, msg)
`define MBPS_ASSERT_NEXT(lbl, clk, trig, cons, msg)
`endif

`endif

// ----- design/mbps_pkg.sv -----
// shared constants and types of the mirror bilinear pixel sampler
// no dependencies
`default_nettype none

package mbps_pkg;

  localparam int POS_W         = 19;
  localparam int SIDE_W        = 10;
  localparam int PIX_W         = 8;
  localparam int SIDE_MIN      = 2;
  localparam int MAX_SIDE_DEF  = 512;
  localparam int FRAC_BITS_DEF = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 10'd512;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // classification made by the front end
  typedef struct packed {
    op_t  op;
    logic flag;
  } item_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             flag;
  } result_t;

endpackage

`default_nettype wire

// ----- design/mbps_ram.sv -----
// generic single-port ram with registered read
// no dependencies
`default_nettype none

module mbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/mbps_front.sv -----
// front end: accepts items, floors and reflects positions, flags bad ones
// depends on mbps_pkg
`default_nettype none

module mbps_front #(
  parameter int MAX_SIDE  = mbps_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = mbps_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_W   = 64
) (
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             operation,
  input  logic signed [mbps_pkg::POS_W-1:0] row_pos,
  input  logic signed [mbps_pkg::POS_W-1:0] col_pos,
  input  logic [mbps_pkg::PIX_W-1:0]        pixel_value,
  input  logic [mbps_pkg::SIDE_W-1:0]       eff_side,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [ENTRY_W-1:0]               q_data
);

  import mbps_pkg::*;

  localparam int ROW_W = $clog2(MAX_SIDE);
  localparam int INT_W = POS_W - FRAC_BITS;
  localparam int CW    = ((INT_W > SIDE_W) ? INT_W : SIDE_W) + 3;

  typedef struct packed {
    item_kind_t           kind;
    logic [ROW_W-1:0]     m0;
    logic [ROW_W-1:0]     m1;
    logic [ROW_W-1:0]     n0;
    logic [ROW_W-1:0]     n1;
    logic [FRAC_BITS-1:0] fa;
    logic [FRAC_BITS-1:0] fb;
    logic [PIX_W-1:0]     pix;
  } entry_t;

  // mirror without repeating the edge pixel
  function automatic logic signed [CW-1:0] reflect(input logic signed [CW-1:0] c,
                                                   input logic signed [CW-1:0] side);
    if (c < CW'(0)) begin
      return -c;
    end else if (c < side) begin
      return c;
    end else begin
      return (side <<< 1) - c - CW'(2);
    end
  endfunction

  function automatic logic in_image(input logic signed [CW-1:0] c,
                                    input logic signed [CW-1:0] side);
    return (c >= CW'(0)) && (c < side);
  endfunction

  logic signed [INT_W-1:0] p_int, q_int;
  logic signed [CW-1:0]    side_s, p, q, p1, q1, rp0, rp1, rq0, rq1;
  logic                    write_ok, sample_ok;
  entry_t                  ent;

  assign p_int  = row_pos[POS_W-1:FRAC_BITS];
  assign q_int  = col_pos[POS_W-1:FRAC_BITS];
  assign p      = CW'(p_int);
  assign q      = CW'(q_int);
  assign p1     = p + CW'(1);
  assign q1     = q + CW'(1);
  assign side_s = signed'(CW'(eff_side));

  assign rp0 = reflect(p, side_s);
  assign rp1 = reflect(p1, side_s);
  assign rq0 = reflect(q, side_s);
  assign rq1 = reflect(q1, side_s);

  assign write_ok  = in_image(p, side_s) && in_image(q, side_s);
  assign sample_ok = in_image(rp0, side_s) && in_image(rp1, side_s) &&
                     in_image(rq0, side_s) && in_image(rq1, side_s);

  always_comb begin
    ent.kind.op   = op_t'(operation);
    ent.kind.flag = (op_t'(operation) == OP_WRITE) ? !write_ok : !sample_ok;
    // an in-range write reflects onto itself
    ent.m0  = ROW_W'(rp0);
    ent.m1  = ROW_W'(rp1);
    ent.n0  = ROW_W'(rq0);
    ent.n1  = ROW_W'(rq1);
    ent.fa  = row_pos[FRAC_BITS-1:0];
    ent.fb  = col_pos[FRAC_BITS-1:0];
    ent.pix = pixel_value;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_data   = ent;

endmodule

`default_nettype wire

// ----- design/mbps_queue.sv -----
// short fifo between front end and back end
// depends on mbps_pkg
`default_nettype none

module mbps_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mbps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             valid
);

  import mbps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr, wr_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign dout  = slots[rd_ptr];
  assign valid = (count != '0);
  assign full  = (count == CNT_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

// ----- design/mbps_back.sv -----
// back end: issues pixel accesses, blends the four neighbors, holds the result
// depends on mbps_pkg and mbps_ram
`default_nettype none

module mbps_back #(
  parameter int MAX_SIDE  = mbps_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = mbps_pkg::FRAC_BITS_DEF,
  parameter int ENTRY_W   = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mbps_pkg::SIDE_W-1:0] eff_side,
  input  logic                       q_valid,
  input  logic [ENTRY_W-1:0]         q_data,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mbps_pkg::result_t          res
);

  import mbps_pkg::*;

  localparam int ROW_W  = $clog2(MAX_SIDE);
  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PW     = ROW_W + SIDE_W;
  localparam int WF     = FRAC_BITS + 1;
  localparam int WW     = 2 * FRAC_BITS + 1;
  localparam int SUM_W  = 2 * FRAC_BITS + PIX_W;

  localparam logic [WF-1:0] ONE       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [1:0]    STEP_LAST = 2'b11;

  typedef struct packed {
    item_kind_t           kind;
    logic [ROW_W-1:0]     m0;
    logic [ROW_W-1:0]     m1;
    logic [ROW_W-1:0]     n0;
    logic [ROW_W-1:0]     n1;
    logic [FRAC_BITS-1:0] fa;
    logic [FRAC_BITS-1:0] fb;
    logic [PIX_W-1:0]     pix;
  } entry_t;

  entry_t           head;
  logic [1:0]       step;
  logic             advance, single, issue, last_beat;
  logic [ROW_W-1:0] m_sel, n_sel;
  logic [WF-1:0]    wr, wc;

  // issue stage registers
  logic              a_valid, a_we, a_rd, a_last, a_flag;
  logic [ADDR_W-1:0] a_addr;
  logic [WW-1:0]     a_w;
  logic [PIX_W-1:0]  a_pix;
  // ram stage registers
  logic              b_valid, b_rd, b_last, b_flag;
  logic [WW-1:0]     b_w;
  logic [PIX_W-1:0]  rdata;
  // product stage registers
  logic              c_valid, c_last, c_flag;
  logic [SUM_W-1:0]  c_prod;
  logic [SUM_W-1:0]  acc, acc_sum;

  assign head    = q_data;
  // whole pipeline freezes while a result waits
  assign advance = !(out_valid && !out_ready);
  assign single  = (head.kind.op == OP_WRITE) || head.kind.flag;
  assign issue   = advance && q_valid;
  assign last_beat = single || (step == STEP_LAST);
  assign q_pop   = issue && last_beat;

  // step bit 1 picks the lower row, bit 0 the right column
  assign m_sel = (step[1] && !single) ? head.m1 : head.m0;
  assign n_sel = (step[0] && !single) ? head.n1 : head.n0;
  assign wr    = step[1] ? {1'b0, head.fa} : ONE - {1'b0, head.fa};
  assign wc    = step[0] ? {1'b0, head.fb} : ONE - {1'b0, head.fb};

  assign acc_sum = acc + c_prod;

  mbps_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (advance && a_valid && (a_we || a_rd)),
    .we    (a_we),
    .addr  (a_addr),
    .wdata (a_pix),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (advance) begin
        a_valid   <= issue;
        b_valid   <= a_valid;
        c_valid   <= b_valid;
        // output register is free whenever the pipeline moves
        out_valid <= c_valid && c_last;
        if (issue) begin
          step <= last_beat ? 2'b00 : step + 2'b01;
        end
        if (c_valid) begin
          if (c_last) begin
            acc <= '0;
          end else begin
            acc <= acc_sum;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_we   <= (head.kind.op == OP_WRITE) && !head.kind.flag;
      a_rd   <= (head.kind.op == OP_SAMPLE) && !head.kind.flag;
      a_last <= last_beat;
      a_flag <= head.kind.flag;
      a_addr <= ADDR_W'(PW'(m_sel) * PW'(eff_side) + PW'(n_sel));
      a_w    <= WW'(WW'(wr) * WW'(wc));
      a_pix  <= head.pix;

      b_rd   <= a_rd;
      b_last <= a_last;
      b_flag <= a_flag;
      b_w    <= a_w;

      c_last <= b_last;
      c_flag <= b_flag;
      c_prod <= b_rd ? SUM_W'(SUM_W'(b_w) * SUM_W'(rdata)) : '0;

      if (c_valid && c_last) begin
        res.value <= acc_sum[SUM_W-1 -: PIX_W];
        res.flag  <= c_flag;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/mirror_bilinear_pixel_sampler_top.sv -----
// mirror bilinear pixel sampler, top level; depends on mbps_pkg, mbps_front,
// mbps_queue, mbps_back, mbps_ram and the assertion macro header
//
// usage: a square 8-bit image lives in a single-port pixel memory. operation 0
// stores pixel_value at the floor of (row_pos, col_pos); operation 1 blends the
// four neighbors of a Q.8 position, mirrored at the edges, truncated toward 0.
// every accepted input beat gives exactly one output beat, in order. out_of_range
// marks an ignored write or a sample whose mirrored neighbor is still outside;
// its sample_value is 0, as is the value of every write.
// cfg_wr_en/cfg_wr_data set image_side (clamped to 2..MAX_SIDE, and to 1023 at most); write it only
// while idle. input and output are valid/ready channels.
// every item passes the queue, then the issue, ram and product stages and the output
// register. writes go at one per cycle while the receiver keeps up; a sample makes
// four reads on the one memory port, so the next item waits until they are issued.
// reset clears the queue and pipeline and sets image_side to 512; the pixel
// memory is not cleared and reads anything until written.
// a stalled receiver freezes the back end; the 2-entry queue still takes
// beats until full, then in_ready drops.
`default_nettype none

`include "mirror_bilinear_pixel_sampler_top_defines.svh"

module mirror_bilinear_pixel_sampler_top #(
  parameter int MAX_SIDE  = mbps_pkg::MAX_SIDE_DEF,
  parameter int FRAC_BITS = mbps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [mbps_pkg::SIDE_W-1:0]        cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              operation,
  input  logic signed [mbps_pkg::POS_W-1:0]  row_pos,
  input  logic signed [mbps_pkg::POS_W-1:0]  col_pos,
  input  logic [mbps_pkg::PIX_W-1:0]         pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mbps_pkg::PIX_W-1:0]         sample_value,
  output logic                              out_of_range
);

  import mbps_pkg::*;

  localparam int ROW_W    = $clog2(MAX_SIDE);
  localparam int ENTRY_W  = 2 + 4 * ROW_W + 2 * FRAC_BITS + PIX_W;
  // largest side the register can actually hold
  localparam int SIDE_CAP = (MAX_SIDE < (1 << SIDE_W) - 1) ? MAX_SIDE : (1 << SIDE_W) - 1;

  logic [SIDE_W-1:0]  image_side, eff_side;
  logic               q_push, q_full, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_din, q_dout;
  result_t            res;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_side <= SIDE_RESET;
    end else if (cfg_wr_en) begin
      image_side <= cfg_wr_data;
    end
  end

  // clamp side into the usable range
  always_comb begin
    if (image_side < SIDE_W'(SIDE_MIN)) begin
      eff_side = SIDE_W'(SIDE_MIN);
    end else if (image_side > SIDE_W'(SIDE_CAP)) begin
      eff_side = SIDE_W'(SIDE_CAP);
    end else begin
      eff_side = image_side;
    end
  end

  // front end: classify and reflect
  mbps_front #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .row_pos     (row_pos),
    .col_pos     (col_pos),
    .pixel_value (pixel_value),
    .eff_side    (eff_side),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_din)
  );

  // decouples front and back stalls
  mbps_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .valid (q_valid)
  );

  // back end: memory access, blend, output register
  mbps_back #(
    .MAX_SIDE  (MAX_SIDE),
    .FRAC_BITS (FRAC_BITS),
    .ENTRY_W   (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .eff_side  (eff_side),
    .q_valid   (q_valid),
    .q_data    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign sample_value = res.value;
  assign out_of_range = res.flag;

  // flagged beats never carry a value; writes carry none either, unchecked here
  `MBPS_ASSERT_IMPLY(a_flag_zero, clk, rst, out_valid && out_of_range, sample_value == '0, "flagged beat with nonzero value")
  // reset empties the queue and the output register
  `MBPS_ASSERT_NEXT(a_reset_idle, clk, rst, in_ready && !out_valid, "block not idle after reset")
  // back pressure only comes from a queue holding work
  `MBPS_ASSERT_IMPLY(a_full_has_head, clk, rst, !in_ready, q_valid && !q_push, "input stalled without queued work")

endmodule

`default_nettype wire

// ----- tb/sv/pixel_result_checker.sv -----
`timescale 1ns / 1ps
// pixel_result_checker: follows the side register and both beat channels of the sampler,
// predicts each result from its own image copy and compares output beats in order
// depends on mbps_pkg only
module pixel_result_checker
  import mbps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [SIDE_W-1:0]        cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     operation,
  input  logic signed [POS_W-1:0]  row_pos,
  input  logic signed [POS_W-1:0]  col_pos,
  input  logic [PIX_W-1:0]         pixel_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [PIX_W-1:0]         sample_value,
  input  logic                     out_of_range,
  output int                       error_count,
  output int                       pending,
  output int                       beats_checked,
  output int                       flagged_count
);

  localparam int SCALE = 1 << FRAC_BITS_DEF;

  logic [PIX_W-1:0]  image_copy [MAX_SIDE_DEF*MAX_SIDE_DEF];
  logic [SIDE_W-1:0] side_reg;
  result_t           expected_pixels [$];

  function automatic int clamp_side(logic [SIDE_W-1:0] raw);
    if (raw < SIDE_MIN) return SIDE_MIN;
    if (raw > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return int'(raw);
  endfunction

  // mirror about the edges, edge pixel not repeated
  function automatic int mirror_coord(int c, int side);
    if (c < 0) return -c;
    if (c < side) return c;
    return 2 * side - c - 2;
  endfunction

  function automatic result_t predict_pixel(op_t op, logic signed [POS_W-1:0] rp,
                                            logic signed [POS_W-1:0] cp,
                                            logic [PIX_W-1:0] pix);
    int      side, p, q, a, b, sum;
    int      rr [2];
    int      cc [2];
    result_t res;
    side = clamp_side(side_reg);
    p    = int'(rp) >>> FRAC_BITS_DEF;
    q    = int'(cp) >>> FRAC_BITS_DEF;
    a    = int'(rp[FRAC_BITS_DEF-1:0]);
    b    = int'(cp[FRAC_BITS_DEF-1:0]);
    res  = '0;
    if (op == OP_WRITE) begin
      if (p >= 0 && p < side && q >= 0 && q < side) image_copy[p*side+q] = pix;
      else res.flag = 1'b1;
      return res;
    end
    for (int i = 0; i < 2; i++) begin
      rr[i] = mirror_coord(p + i, side);
      cc[i] = mirror_coord(q + i, side);
      if (rr[i] < 0 || rr[i] >= side || cc[i] < 0 || cc[i] >= side) res.flag = 1'b1;
    end
    if (res.flag) return res;
    sum = (SCALE - a) * (SCALE - b) * int'(image_copy[rr[0]*side+cc[0]])
        + (SCALE - a) * b * int'(image_copy[rr[0]*side+cc[1]])
        + a * (SCALE - b) * int'(image_copy[rr[1]*side+cc[0]])
        + a * b * int'(image_copy[rr[1]*side+cc[1]]);
    res.value = PIX_W'(sum >> (2 * FRAC_BITS_DEF));
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    $display("checker: beat %0d %s got %0d expected %0d", beats_checked, what, got, want);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      side_reg = SIDE_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_wr_en) side_reg = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("output beat with nothing outstanding", 32'(sample_value), 0);
        end else begin
          want = expected_pixels.pop_front();
          if (sample_value !== want.value)
            report_mismatch("sample_value", 32'(sample_value), 32'(want.value));
          if (out_of_range !== want.flag)
            report_mismatch("out_of_range", 32'(out_of_range), 32'(want.flag));
          if (out_of_range === 1'b1) flagged_count++;
          beats_checked++;
        end
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(predict_pixel(op_t'(operation), row_pos, col_pos,
                                                pixel_value));
    end
    pending = expected_pixels.size();
  end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: top of the mirror bilinear pixel sampler bench; writes the side register,
// drives input beats and output backpressure, and gives the verdict
// depends on mbps_pkg, mirror_bilinear_pixel_sampler_top and pixel_result_checker
module testbench;
  import mbps_pkg::*;

  localparam int SCALE         = 1 << FRAC_BITS_DEF;
  localparam int FULL_FILL_MAX = 16;   // sides up to this get every pixel written
  localparam int CORNER        = 4;    // larger sides: 4x4 block written at each corner
  localparam int HOLD_CYCLES   = 200;  // long receiver hold-off, once
  localparam int HOLD_PHASE    = 5;
  localparam int SETTLE_CYCLES = 16;   // margin after the last result, room for strays
  // slowest correct progress: a sample behind the largest input gap and receiver
  // stall, or the long hold-off; this is several times the worst of those
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASES        = 12;

  // side settings, the clamped ones (0, 1, 600, 1023) among them
  logic [SIDE_W-1:0] phase_side [PHASES] = '{10'd4, 10'd2, 10'd0, 10'd1, 10'd3, 10'd7,
                                             10'd16, 10'd1023, 10'd13, 10'd600, 10'd512,
                                             10'd5};
  int phase_beats [PHASES] = '{100, 80, 40, 40, 80, 130, 120, 120, 120, 80, 120, 80};
  bit phase_paced [PHASES] = '{1, 1, 0, 1, 1, 0, 1, 1, 1, 0, 1, 1};

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [SIDE_W-1:0]       cfg_wr_data;
  logic                    in_valid;
  logic                    in_ready;
  logic                    operation;
  logic signed [POS_W-1:0] row_pos;
  logic signed [POS_W-1:0] col_pos;
  logic [PIX_W-1:0]        pixel_value;
  logic                    out_valid;
  logic                    out_ready;
  logic [PIX_W-1:0]        sample_value;
  logic                    out_of_range;

  int errors;
  int pending;
  int beats_checked;
  int flagged_count;

  // stimulus bookkeeping: which memory addresses hold a written pixel
  bit pix_known [MAX_SIDE_DEF*MAX_SIDE_DEF];
  int cur_side;
  int samples_sent;
  int quiet_cycles;
  bit pace_on;
  bit hold_request;

  mirror_bilinear_pixel_sampler_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .row_pos      (row_pos),
    .col_pos      (col_pos),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_value (sample_value),
    .out_of_range (out_of_range)
  );

  pixel_result_checker result_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .row_pos       (row_pos),
    .col_pos       (col_pos),
    .pixel_value   (pixel_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sample_value  (sample_value),
    .out_of_range  (out_of_range),
    .error_count   (errors),
    .pending       (pending),
    .beats_checked (beats_checked),
    .flagged_count (flagged_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int side_in_use(logic [SIDE_W-1:0] raw);
    if (raw < SIDE_MIN) return SIDE_MIN;
    if (raw > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return int'(raw);
  endfunction

  function automatic logic signed [POS_W-1:0] to_fixed(int whole, int frac);
    logic signed [POS_W-1:0] v;
    v = POS_W'(whole * SCALE + frac);
    return v;
  endfunction

  // coordinate after mirroring at the current side
  function automatic int fold(int c);
    if (c < 0) return -c;
    if (c < cur_side) return c;
    return 2 * cur_side - c - 2;
  endfunction

  // a sample may only touch pixels that were written; neighbors still outside are fine
  function automatic bit reads_known(logic signed [POS_W-1:0] rp, logic signed [POS_W-1:0] cp);
    int p, q, r, c;
    p = int'(rp) >>> FRAC_BITS_DEF;
    q = int'(cp) >>> FRAC_BITS_DEF;
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) begin
        r = fold(p + i);
        c = fold(q + j);
        if (r >= 0 && r < cur_side && c >= 0 && c < cur_side && !pix_known[r*cur_side+c])
          return 1'b0;
      end
    return 1'b1;
  endfunction

  // small sides: anywhere within one reflection and a little past it
  // large sides: around either written corner, through the mirror line
  function automatic int pick_coord();
    if (cur_side <= FULL_FILL_MAX)
      return int'($urandom_range(0, 3 * cur_side + 1)) - cur_side - 1;
    if ($urandom_range(0, 1))
      return int'($urandom_range(0, 5)) - 3;
    return cur_side - CORNER + int'($urandom_range(0, 5));
  endfunction

  // exact pixel positions and the largest fraction show up often
  function automatic int pick_frac();
    int k;
    k = $urandom_range(0, 7);
    if (k < 2) return 0;
    if (k == 2) return SCALE - 1;
    return $urandom_range(0, SCALE - 1);
  endfunction

  // one input beat; valid stays up until it is taken
  task automatic send_beat(op_t op, logic signed [POS_W-1:0] rp,
                           logic signed [POS_W-1:0] cp, logic [PIX_W-1:0] pix);
    int gap, p, q;
    gap = pace_on ? $urandom_range(0, 3) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    = 1'b1;
    operation   = op;
    row_pos     = rp;
    col_pos     = cp;
    pixel_value = pix;
    do @(posedge clk); while (!in_ready);
    if (op == OP_WRITE) begin
      p = int'(rp) >>> FRAC_BITS_DEF;
      q = int'(cp) >>> FRAC_BITS_DEF;
      if (p >= 0 && p < cur_side && q >= 0 && q < cur_side) pix_known[p*cur_side+q] = 1'b1;
    end else begin
      samples_sent++;
    end
  endtask

  task automatic send_write(int r, int c, int pix);
    send_beat(OP_WRITE, to_fixed(r, $urandom_range(0, SCALE - 1)),
              to_fixed(c, $urandom_range(0, SCALE - 1)), PIX_W'(pix));
  endtask

  // wide draws cover the whole position range; retries keep off unwritten pixels
  task automatic send_sample(bit wide);
    logic signed [POS_W-1:0] rp, cp;
    int tries;
    bit found;
    found = 1'b0;
    tries = 0;
    while (!found && tries < 50) begin
      if (wide) begin
        rp = POS_W'($urandom);
        cp = POS_W'($urandom);
      end else begin
        rp = to_fixed(pick_coord(), pick_frac());
        cp = to_fixed(pick_coord(), pick_frac());
      end
      found = reads_known(rp, cp);
      tries++;
    end
    if (!found) begin
      rp = to_fixed(0, 0);
      cp = to_fixed(0, 0);
    end
    send_beat(OP_SAMPLE, rp, cp, PIX_W'($urandom));
  endtask

  // register writes only with nothing in flight and valid low
  task automatic set_side(logic [SIDE_W-1:0] raw);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = raw;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_side  = side_in_use(raw);
  endtask

  task automatic fill_image();
    int r, c;
    if (cur_side <= FULL_FILL_MAX) begin
      for (r = 0; r < cur_side; r++)
        for (c = 0; c < cur_side; c++) send_write(r, c, $urandom);
    end else begin
      for (int i = 0; i < 2 * CORNER; i++)
        for (int j = 0; j < 2 * CORNER; j++) begin
          r = (i < CORNER) ? i : cur_side - 2 * CORNER + i;
          c = (j < CORNER) ? j : cur_side - 2 * CORNER + j;
          send_write(r, c, $urandom);
        end
    end
  endtask

  // mostly samples near the image, some anywhere, writes in and out of the image
  task automatic random_beats(int count);
    int kind;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 55)
        send_sample(1'b0);
      else if (kind < 65)
        send_sample(1'b1);
      else if (kind < 90)
        send_write($urandom_range(0, cur_side - 1), $urandom_range(0, cur_side - 1), $urandom);
      else
        send_beat(OP_WRITE, POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom));
    end
  endtask

  initial begin : stimulus
    rst          = 1'b1;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_valid     = 1'b0;
    operation    = OP_WRITE;
    row_pos      = '0;
    col_pos      = '0;
    pixel_value  = '0;
    pace_on      = 1'b0;
    hold_request = 1'b0;
    samples_sent = 0;
    cur_side     = side_in_use(SIDE_RESET);
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed part at the reset side of 512: corner blocks, extremes, edge mirrors
    send_write(0, 0, 0);
    send_write(0, 1, 255);
    send_write(1, 0, 128);
    send_write(1, 1, 77);
    send_write(511, 511, 255);
    send_write(510, 511, 1);
    send_write(511, 510, 254);
    send_write(510, 510, 100);
    // writes outside the image, at the position extremes, and with fraction bits set
    send_beat(OP_WRITE, to_fixed(-1, 0), to_fixed(0, 0), 8'd9);
    send_beat(OP_WRITE, to_fixed(512, 0), to_fixed(3, 0), 8'd33);
    send_beat(OP_WRITE, {1'b1, {(POS_W-1){1'b0}}}, to_fixed(0, 0), 8'd1);
    send_beat(OP_WRITE, to_fixed(0, 0), {1'b0, {(POS_W-1){1'b1}}}, 8'd2);
    send_beat(OP_WRITE, to_fixed(1, SCALE / 2), to_fixed(0, SCALE - 1), 8'd200);
    // samples: exact, half, largest fraction, mirrored at both edges
    send_beat(OP_SAMPLE, to_fixed(0, 0), to_fixed(0, 0), 8'hff);
    send_beat(OP_SAMPLE, to_fixed(0, SCALE / 2), to_fixed(0, SCALE / 2), 8'h00);
    send_beat(OP_SAMPLE, to_fixed(0, SCALE - 1), to_fixed(0, SCALE - 1), 8'h5a);
    send_beat(OP_SAMPLE, to_fixed(-1, SCALE / 2), to_fixed(0, SCALE / 4), 8'h00);
    send_beat(OP_SAMPLE, to_fixed(-1, 0), to_fixed(-1, 0), 8'h00);
    send_beat(OP_SAMPLE, to_fixed(511, SCALE / 2), to_fixed(511, SCALE / 2), 8'h00);
    send_beat(OP_SAMPLE, to_fixed(511, 0), to_fixed(510, 0), 8'h00);
    // beyond a single reflection
    send_beat(OP_SAMPLE, to_fixed(1022, 3), to_fixed(0, 0), 8'h00);
    send_beat(OP_SAMPLE, {1'b0, {(POS_W-1){1'b1}}}, to_fixed(0, 0), 8'h00);
    send_beat(OP_SAMPLE, to_fixed(0, 0), {1'b1, {(POS_W-1){1'b0}}}, 8'h00);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_side(phase_side[ph]);
      pace_on = phase_paced[ph];
      fill_image();
      // receiver stalls for a long stretch while beats keep coming
      if (ph == HOLD_PHASE) hold_request = 1'b1;
      random_beats(phase_beats[ph]);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("summary: %0d result beats checked over %0d side settings, %0d were samples",
             beats_checked, PHASES + 1, samples_sent);
    $display("summary: %0d results flagged out of range, one receiver hold-off of %0d cycles",
             flagged_count, HOLD_CYCLES);
    if (errors == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

  // receiver: random stall before each beat in paced phases, one long hold-off on request
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      stall = pace_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // watchdog: any beat or register write counts as progress
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

endmodule

// ----- mirror_bilinear_pixel_sampler_top.f -----
+incdir+design
design/mbps_pkg.sv
design/mbps_ram.sv
design/mbps_front.sv
design/mbps_queue.sv
design/mbps_back.sv
design/mirror_bilinear_pixel_sampler_top.sv
tb/sv/pixel_result_checker.sv
tb/sv/testbench.sv
